// ===== rtl/dsa_signature_verify_top_macros.svh =====
// assertion macros for the signature verifier
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef DSA_SIGNATURE_VERIFY_TOP_MACROS_SVH
`define DSA_SIGNATURE_VERIFY_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/dsv_pkg.sv =====
// shared types and constants of the signature verifier
// no dependencies
`timescale 1ns / 1ps
package dsv_pkg;

  localparam int BYTE_W    = 8;
  localparam int SIG_W     = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY   = 2'd3;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_HASH_ADD,
    OP_HASH_DIV,
    OP_HASH_END,
    OP_EMIT_ZERO,
    OP_INV_INIT,
    OP_INV_DIV,
    OP_INV_DIV_END,
    OP_INV_MUL_END,
    OP_U1_START,
    OP_U1_END,
    OP_U2_END,
    OP_BASE_END,
    OP_ACC_START,
    OP_ACC_END,
    OP_SQR_START,
    OP_SQR_END,
    OP_POW_SAVE,
    OP_FIN_START,
    OP_FIN_END,
    OP_EMIT
  } dsv_op_t;

  typedef struct packed {
    dsv_op_t op;
  } dsv_cmd_t;

  typedef struct packed {
    logic hash_fast;
    logic last;
    logic q_lt2;
    logic p_zero;
    logic inv_go;
    logic e_zero;
    logic e_lsb;
    logic div_done;
    logic mul_done;
  } dsv_status_t;

endpackage

// ===== rtl/dsa_signature_verify_top.sv =====
// signature verifier top level
// uses dsv_pkg, dsv_ctrl and dsv_datapath
`timescale 1ns / 1ps
// usage
// - input transaction: drive in_* with start high while busy is low; one message
//   byte per transaction, in_last_byte marks the final one and carries in_sig_r/s
// - a plain byte is added to the hash directly when hash and byte are below q
//   (or q is below 2), otherwise the hash is reduced on the shared divider
// - a last byte starts verification: inverse by extended euclid, two products,
//   two modular exponentiations, a final product and reduction, all on one
//   bit-serial divider and one shift-add multiplier (one multiplier bit per
//   cycle), both D = max(MODULUS_WIDTH, 32) bits wide; if q is below 2 or p is
//   zero, a zero check value is emitted instead
// - a new transaction is taken once busy falls
// - result: out_strobe is high for one cycle with check value, hash and valid
//   flag; the receiver cannot stall, the result must be taken in that cycle
// - configuration: cfg_valid/cfg_ready write channel, always ready; the user must
//   write it only while busy is low, the block itself does not enforce this
// - reset: synchronous rst_n restores p=23, q=11, g=4, y=8 and clears the hash
module dsa_signature_verify_top #(
  parameter int MODULUS_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dsv_pkg::BYTE_W-1:0]     in_message_byte,
  input  logic                           in_last_byte,
  input  logic [dsv_pkg::SIG_W-1:0]      in_sig_r,
  input  logic [dsv_pkg::SIG_W-1:0]      in_sig_s,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [MODULUS_WIDTH-1:0]       cfg_data,
  output logic                           out_strobe,
  output logic [dsv_pkg::OUT_W-1:0]      out_check_value,
  output logic [dsv_pkg::OUT_W-1:0]      out_message_hash,
  output logic                           out_signature_valid
);

  dsv_pkg::dsv_cmd_t    cmd;
  dsv_pkg::dsv_status_t status;

  assign cfg_ready = 1'b1;

  dsv_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  dsv_datapath #(.MODULUS_WIDTH(MODULUS_WIDTH)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_message_byte     (in_message_byte),
    .in_last_byte        (in_last_byte),
    .in_sig_r            (in_sig_r),
    .in_sig_s            (in_sig_s),
    .cmd                 (cmd),
    .status              (status),
    .out_strobe          (out_strobe),
    .out_check_value     (out_check_value),
    .out_message_hash    (out_message_hash),
    .out_signature_valid (out_signature_valid)
  );

endmodule

// ===== rtl/dsv_divider.sv =====
// restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
module dsv_divider #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign done    = busy_r && (cnt_r == '0);
  assign quo     = quo_r;
  assign rem     = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/dsv_mulmod.sv =====
// modular multiplier, shift and add over one multiplier bit per cycle
// no package dependencies
`timescale 1ns / 1ps
module dsv_mulmod #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] res
);

  logic         busy_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] a_r;
  logic [W-1:0] b_r;
  logic [W-1:0] m_r;

  function automatic logic [W-1:0] add_mod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] mm);
    logic [W-1:0] room;
    room = mm - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  assign done = busy_r && (b_r == '0);
  assign res  = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= add_mod(acc_r, a_r, m_r);
      end
      a_r <= add_mod(a_r, a_r, m_r);
      b_r <= b_r >> 1;
    end
  end

endmodule

// ===== rtl/dsv_datapath.sv =====
// datapath: configuration, hash, inverse, exponent registers and result
// uses dsv_pkg, dsv_divider and dsv_mulmod
`timescale 1ns / 1ps
module dsv_datapath #(
  parameter int MODULUS_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [MODULUS_WIDTH-1:0]       cfg_data,
  input  logic [dsv_pkg::BYTE_W-1:0]     in_message_byte,
  input  logic                           in_last_byte,
  input  logic [dsv_pkg::SIG_W-1:0]      in_sig_r,
  input  logic [dsv_pkg::SIG_W-1:0]      in_sig_s,
  input  dsv_pkg::dsv_cmd_t              cmd,
  output dsv_pkg::dsv_status_t           status,
  output logic                           out_strobe,
  output logic [dsv_pkg::OUT_W-1:0]      out_check_value,
  output logic [dsv_pkg::OUT_W-1:0]      out_message_hash,
  output logic                           out_signature_valid
);

  localparam int W = MODULUS_WIDTH;
  localparam int D = (MODULUS_WIDTH > 32) ? MODULUS_WIDTH : 32;
  localparam int N = D + 1;

  logic [W-1:0] p_r, q_r, g_r, y_r;
  logic [D-1:0] p_x, q_x, g_x, y_x;

  logic [D-1:0]               h_r;
  logic [dsv_pkg::BYTE_W-1:0] byte_r;
  logic                       last_r;
  logic [D-1:0] r_r, s_r, a_r, dv_r, cp_r, cc_r, rem_r;
  logic [D-1:0] u1_r, u2_r, e_r, acc_r, base_r, pa_r;
  logic [D-1:0] byte_x, one_p;

  logic                       strobe_r;
  logic [dsv_pkg::OUT_W-1:0]  check_r, hash_r;
  logic                       valid_r;

  logic         div_start, div_done;
  logic [N-1:0] div_num, div_quo;
  logic [D-1:0] div_den, div_rem;
  logic         mul_start, mul_done;
  logic [D-1:0] mul_a, mul_b, mul_m, mul_res;

  function automatic logic [D-1:0] add_mod(logic [D-1:0] x, logic [D-1:0] y,
                                           logic [D-1:0] mm);
    logic [D-1:0] room;
    room = mm - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  function automatic logic [D-1:0] sub_mod(logic [D-1:0] x, logic [D-1:0] y,
                                           logic [D-1:0] mm);
    return (x >= y) ? (x - y) : (x + (mm - y));
  endfunction

  assign p_x    = D'(p_r);
  assign q_x    = D'(q_r);
  assign g_x    = D'(g_r);
  assign y_x    = D'(y_r);
  assign byte_x = D'(byte_r);
  assign one_p  = (p_x == D'(1)) ? '0 : D'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= W'(23);
      q_r <= W'(11);
      g_r <= W'(4);
      y_r <= W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsv_pkg::REG_PRIME: p_r <= cfg_data;
        dsv_pkg::REG_ORDER: q_r <= cfg_data;
        dsv_pkg::REG_GEN:   g_r <= cfg_data;
        dsv_pkg::REG_KEY:   y_r <= cfg_data;
      endcase
    end
  end

  // operand steering for the shared units
  always_comb begin
    div_start = 1'b0;
    div_num   = N'(a_r);
    div_den   = dv_r;
    mul_start = 1'b0;
    mul_a     = cc_r;
    mul_b     = h_r;
    mul_m     = q_x;
    unique case (cmd.op)
      dsv_pkg::OP_HASH_DIV: begin
        div_start = 1'b1;
        div_num   = N'(h_r) + N'(byte_x);
        div_den   = q_x;
      end
      dsv_pkg::OP_INV_DIV: begin
        div_start = 1'b1;
      end
      dsv_pkg::OP_INV_DIV_END: begin
        mul_start = 1'b1;
        mul_a     = cp_r;
        mul_b     = div_quo[D-1:0];
      end
      dsv_pkg::OP_U1_START: begin
        mul_start = 1'b1;
      end
      dsv_pkg::OP_U1_END: begin
        mul_start = 1'b1;
        mul_b     = r_r;
      end
      dsv_pkg::OP_U2_END: begin
        div_start = 1'b1;
        div_num   = N'(g_x);
        div_den   = p_x;
      end
      dsv_pkg::OP_POW_SAVE: begin
        div_start = 1'b1;
        div_num   = N'(y_x);
        div_den   = p_x;
      end
      dsv_pkg::OP_ACC_START: begin
        mul_start = 1'b1;
        mul_a     = acc_r;
        mul_b     = base_r;
        mul_m     = p_x;
      end
      dsv_pkg::OP_ACC_END, dsv_pkg::OP_SQR_START: begin
        mul_start = 1'b1;
        mul_a     = base_r;
        mul_b     = base_r;
        mul_m     = p_x;
      end
      dsv_pkg::OP_FIN_START: begin
        mul_start = 1'b1;
        mul_a     = pa_r;
        mul_b     = acc_r;
        mul_m     = p_x;
      end
      dsv_pkg::OP_FIN_END: begin
        div_start = 1'b1;
        div_num   = N'(mul_res);
        div_den   = q_x;
      end
      default: begin
      end
    endcase
  end

  dsv_divider #(.NUM_W(N), .DEN_W(D)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  dsv_mulmod #(.W(D)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mul_m),
    .done  (mul_done),
    .res   (mul_res)
  );

  // running hash and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op == dsv_pkg::OP_EMIT) || (cmd.op == dsv_pkg::OP_EMIT_ZERO);
      if (cmd.op == dsv_pkg::OP_HASH_ADD) begin
        h_r <= (q_x < D'(2)) ? '0 : add_mod(h_r, byte_x, q_x);
      end else if (cmd.op == dsv_pkg::OP_HASH_END) begin
        h_r <= div_rem;
      end else if ((cmd.op == dsv_pkg::OP_EMIT) || (cmd.op == dsv_pkg::OP_EMIT_ZERO)) begin
        h_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      dsv_pkg::OP_CAPTURE: begin
        byte_r <= in_message_byte;
        last_r <= in_last_byte;
        r_r    <= D'(in_sig_r);
        s_r    <= D'(in_sig_s);
      end
      dsv_pkg::OP_INV_INIT: begin
        a_r  <= s_r;
        dv_r <= q_x;
        cp_r <= '0;
        cc_r <= D'(1);
      end
      dsv_pkg::OP_INV_DIV_END: rem_r <= div_rem;
      dsv_pkg::OP_INV_MUL_END: begin
        cp_r <= sub_mod(cc_r, mul_res, q_x);
        a_r  <= dv_r;
        dv_r <= rem_r;
        cc_r <= cp_r;
      end
      dsv_pkg::OP_U1_END: u1_r <= mul_res;
      dsv_pkg::OP_U2_END: begin
        u2_r  <= mul_res;
        e_r   <= u1_r;
        acc_r <= one_p;
      end
      dsv_pkg::OP_BASE_END: base_r <= div_rem;
      dsv_pkg::OP_ACC_END:  acc_r <= mul_res;
      dsv_pkg::OP_SQR_END: begin
        base_r <= mul_res;
        e_r    <= e_r >> 1;
      end
      dsv_pkg::OP_POW_SAVE: begin
        pa_r  <= acc_r;
        e_r   <= u2_r;
        acc_r <= one_p;
      end
      dsv_pkg::OP_EMIT: begin
        check_r <= div_rem[dsv_pkg::OUT_W-1:0];
        hash_r  <= h_r[dsv_pkg::OUT_W-1:0];
        valid_r <= (div_rem == r_r);
      end
      dsv_pkg::OP_EMIT_ZERO: begin
        check_r <= '0;
        hash_r  <= h_r[dsv_pkg::OUT_W-1:0];
        valid_r <= (r_r == '0);
      end
      default: begin
      end
    endcase
  end

  assign status.hash_fast = (q_x < D'(2)) || ((h_r < q_x) && (byte_x < q_x));
  assign status.last      = last_r;
  assign status.q_lt2     = q_x < D'(2);
  assign status.p_zero    = p_x == '0;
  assign status.inv_go    = (a_r > D'(1)) && (dv_r != '0);
  assign status.e_zero    = e_r == '0;
  assign status.e_lsb     = e_r[0];
  assign status.div_done  = div_done;
  assign status.mul_done  = mul_done;

  assign out_strobe          = strobe_r;
  assign out_check_value     = check_r;
  assign out_message_hash    = hash_r;
  assign out_signature_valid = valid_r;

endmodule

// ===== rtl/dsv_ctrl.sv =====
// controller: sequences hash, inverse, exponentiations and result
// uses dsv_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dsa_signature_verify_top_macros.svh"
module dsv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dsv_pkg::dsv_status_t status,
  output dsv_pkg::dsv_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_HASH   = 15'h0002,
    S_HASH_W = 15'h0004,
    S_CHK    = 15'h0008,
    S_INV    = 15'h0010,
    S_INV_DW = 15'h0020,
    S_INV_MW = 15'h0040,
    S_U1_W   = 15'h0080,
    S_U2_W   = 15'h0100,
    S_BASE_W = 15'h0200,
    S_POW    = 15'h0400,
    S_ACC_W  = 15'h0800,
    S_SQR_W  = 15'h1000,
    S_FIN_MW = 15'h2000,
    S_FIN_DW = 15'h4000
  } dsv_state_t;

  dsv_state_t state_r, state_nxt;
  logic       second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd.op     = dsv_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = dsv_pkg::OP_CAPTURE;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (status.hash_fast) begin
          cmd.op    = dsv_pkg::OP_HASH_ADD;
          state_nxt = status.last ? S_CHK : S_IDLE;
        end else begin
          cmd.op    = dsv_pkg::OP_HASH_DIV;
          state_nxt = S_HASH_W;
        end
      end
      S_HASH_W: begin
        if (status.div_done) begin
          cmd.op    = dsv_pkg::OP_HASH_END;
          state_nxt = status.last ? S_CHK : S_IDLE;
        end
      end
      S_CHK: begin
        second_nxt = 1'b0;
        if (status.q_lt2 || status.p_zero) begin
          cmd.op    = dsv_pkg::OP_EMIT_ZERO;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = dsv_pkg::OP_INV_INIT;
          state_nxt = S_INV;
        end
      end
      S_INV: begin
        if (status.inv_go) begin
          cmd.op    = dsv_pkg::OP_INV_DIV;
          state_nxt = S_INV_DW;
        end else begin
          cmd.op    = dsv_pkg::OP_U1_START;
          state_nxt = S_U1_W;
        end
      end
      S_INV_DW: begin
        if (status.div_done) begin
          cmd.op    = dsv_pkg::OP_INV_DIV_END;
          state_nxt = S_INV_MW;
        end
      end
      S_INV_MW: begin
        if (status.mul_done) begin
          cmd.op    = dsv_pkg::OP_INV_MUL_END;
          state_nxt = S_INV;
        end
      end
      S_U1_W: begin
        if (status.mul_done) begin
          cmd.op    = dsv_pkg::OP_U1_END;
          state_nxt = S_U2_W;
        end
      end
      S_U2_W: begin
        if (status.mul_done) begin
          cmd.op    = dsv_pkg::OP_U2_END;
          state_nxt = S_BASE_W;
        end
      end
      S_BASE_W: begin
        if (status.div_done) begin
          cmd.op    = dsv_pkg::OP_BASE_END;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        priority if (status.e_zero && !second_r) begin
          cmd.op     = dsv_pkg::OP_POW_SAVE;
          second_nxt = 1'b1;
          state_nxt  = S_BASE_W;
        end else if (status.e_zero) begin
          cmd.op    = dsv_pkg::OP_FIN_START;
          state_nxt = S_FIN_MW;
        end else if (status.e_lsb) begin
          cmd.op    = dsv_pkg::OP_ACC_START;
          state_nxt = S_ACC_W;
        end else begin
          cmd.op    = dsv_pkg::OP_SQR_START;
          state_nxt = S_SQR_W;
        end
      end
      S_ACC_W: begin
        if (status.mul_done) begin
          cmd.op    = dsv_pkg::OP_ACC_END;
          state_nxt = S_SQR_W;
        end
      end
      S_SQR_W: begin
        if (status.mul_done) begin
          cmd.op    = dsv_pkg::OP_SQR_END;
          state_nxt = S_POW;
        end
      end
      S_FIN_MW: begin
        if (status.mul_done) begin
          cmd.op    = dsv_pkg::OP_FIN_END;
          state_nxt = S_FIN_DW;
        end
      end
      S_FIN_DW: begin
        if (status.div_done) begin
          cmd.op    = dsv_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_idle_units_quiet, clk, rst_n, state_r == S_IDLE,
               !status.div_done && !status.mul_done)
  `ASSERT_IMPL(a_emit_only_last, clk, rst_n,
               (cmd.op == dsv_pkg::OP_EMIT) || (cmd.op == dsv_pkg::OP_EMIT_ZERO), status.last)
  `ASSERT_IMPL(a_busy_from_start, clk, rst_n, $rose(busy), $past(start))

endmodule

// ===== tb/sv/dsa_signature_verify_top_tb.sv =====
// self-checking testbench of the signature verifier top level
// uses dsv_pkg and dsa_signature_verify_top; a built-in predictor checks every result
`timescale 1ns / 1ps
module dsa_signature_verify_top_tb;

  localparam int MW        = 32;
  localparam int BYTE_W    = dsv_pkg::BYTE_W;
  localparam int SIG_W     = dsv_pkg::SIG_W;
  localparam int OUT_W     = dsv_pkg::OUT_W;
  localparam int CFG_IDX_W = dsv_pkg::CFG_IDX_W;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [MW-1:0]        data;
    logic [BYTE_W-1:0]    mbyte;
    bit                   last;
    logic [SIG_W-1:0]     r;
    logic [SIG_W-1:0]     s;
    bit                   fixed;
    logic [OUT_W-1:0]     ev;
    logic [OUT_W-1:0]     eh;
    bit                   evalid;
  } row_t;

  typedef struct {
    logic [OUT_W-1:0] v;
    logic [OUT_W-1:0] h;
    bit               ok;
  } verdict_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [BYTE_W-1:0]    in_message_byte;
  logic                 in_last_byte;
  logic [SIG_W-1:0]     in_sig_r;
  logic [SIG_W-1:0]     in_sig_s;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MW-1:0]        cfg_data;
  logic                 out_strobe;
  logic [OUT_W-1:0]     out_check_value;
  logic [OUT_W-1:0]     out_message_hash;
  logic                 out_signature_valid;

  longint unsigned mdl_p, mdl_q, mdl_g, mdl_y, mdl_hash;
  verdict_t        pending_verdicts[$];
  int              mismatches;
  int              idle_pct;
  row_t            plan[$];

  dsa_signature_verify_top #(.MODULUS_WIDTH(MW)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_message_byte(in_message_byte), .in_last_byte(in_last_byte),
    .in_sig_r(in_sig_r), .in_sig_s(in_sig_s),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_strobe(out_strobe),
    .out_check_value(out_check_value), .out_message_hash(out_message_hash),
    .out_signature_valid(out_signature_valid)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic longint unsigned mulm(longint unsigned a, longint unsigned b,
                                           longint unsigned m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic longint unsigned powm(longint unsigned b, longint unsigned e,
                                           longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulm(acc, b, m);
      b = mulm(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned invm(longint unsigned a, longint unsigned m);
    longint unsigned dv, cp, cc, quo, rem, nxt, t;
    dv = m; cp = 0; cc = 1;
    while (a > 1 && dv != 0) begin
      quo = a / dv;
      rem = a % dv;
      t = mulm(quo, cp, m);
      nxt = (cc >= t) ? cc - t : cc + (m - t);
      a = dv; dv = rem; cc = cp; cp = nxt;
    end
    return cc;
  endfunction

  // fold one byte into the hash; returns 1 and the verdict on a last byte
  function automatic bit absorb_byte(logic [BYTE_W-1:0] b, bit last,
                                     logic [SIG_W-1:0] r, logic [SIG_W-1:0] s,
                                     output verdict_t vd);
    longint unsigned w, u1, u2, v;
    v = 0;
    if (mdl_q < 2) mdl_hash = 0;
    else mdl_hash = ((mdl_hash % mdl_q) + (b % mdl_q)) % mdl_q;
    if (!last) return 0;
    if (mdl_q >= 2 && mdl_p != 0) begin
      w = invm(s, mdl_q);
      u1 = mulm(mdl_hash, w, mdl_q);
      u2 = mulm(r, w, mdl_q);
      v = mulm(powm(mdl_g, u1, mdl_p), powm(mdl_y, u2, mdl_p), mdl_p) % mdl_q;
    end
    vd.v = OUT_W'(v & M32);
    vd.h = OUT_W'(mdl_hash & M32);
    vd.ok = (v == r);
    mdl_hash = 0;
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                 logic [OUT_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    verdict_t vd;
    if (rst_n && out_strobe) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected transaction", out_check_value, '0);
      end else begin
        vd = pending_verdicts.pop_front();
        if (out_check_value !== vd.v) report_mismatch("check_value", out_check_value, vd.v);
        if (out_message_hash !== vd.h) report_mismatch("message_hash", out_message_hash, vd.h);
        if (out_signature_valid !== vd.ok)
          report_mismatch("signature_valid", out_signature_valid, vd.ok);
      end
    end
  end

  task automatic drain();
    while (pending_verdicts.size() != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MW-1:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dsv_pkg::REG_PRIME: mdl_p = data;
      dsv_pkg::REG_ORDER: mdl_q = data;
      dsv_pkg::REG_GEN:   mdl_g = data;
      dsv_pkg::REG_KEY:   mdl_y = data;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // returns the verdict expected for this transaction, if any
  task automatic send_byte(logic [BYTE_W-1:0] b, bit last, logic [SIG_W-1:0] r,
                           logic [SIG_W-1:0] s, output bit has, output verdict_t vd);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start = 1'b1;
    in_message_byte = b;
    in_last_byte = last;
    in_sig_r = r;
    in_sig_s = s;
    do @(posedge clk); while (busy);
    has = absorb_byte(b, last, r, s, vd);
    if (has) pending_verdicts.push_back(vd);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [MW-1:0] data);
    row_t rw;
    rw = '{default: '0};
    rw.is_cfg = 1; rw.idx = idx; rw.data = data;
    return rw;
  endfunction

  function automatic row_t byte_row(logic [BYTE_W-1:0] b, bit last, logic [SIG_W-1:0] r,
                                    logic [SIG_W-1:0] s, bit fixed = 0,
                                    logic [OUT_W-1:0] ev = 0, logic [OUT_W-1:0] eh = 0,
                                    bit evalid = 0);
    row_t rw;
    rw = '{default: '0};
    rw.mbyte = b; rw.last = last; rw.r = r; rw.s = s;
    rw.fixed = fixed; rw.ev = ev; rw.eh = eh; rw.evalid = evalid;
    return rw;
  endfunction

  initial begin
    repeat (30) #100_000_000;
    $display("[dsa_signature_verify_top] ERROR");
    $finish;
  end

  initial begin
    bit              has;
    verdict_t        vd;
    longint unsigned qq, pp;
    logic [SIG_W-1:0] rr;
    start = 0; in_message_byte = 0; in_last_byte = 0; in_sig_r = 0; in_sig_s = 0;
    cfg_valid = 0; cfg_index = dsv_pkg::REG_PRIME; cfg_data = 0;
    mismatches = 0; idle_pct = 30;
    mdl_p = 23; mdl_q = 11; mdl_g = 4; mdl_y = 8; mdl_hash = 0;
    rst_n = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;

    plan.push_back(byte_row(8'd255, 1, 0, 0, 1, 5, 2, 0));
    plan.push_back(byte_row(8'd0, 0, 0, 0));
    plan.push_back(byte_row(8'd200, 0, 0, 0));
    plan.push_back(byte_row(8'd7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(dsv_pkg::REG_ORDER, 12));
    plan.push_back(byte_row(8'd5, 1, 3, 6));
    plan.push_back(cfg_row(dsv_pkg::REG_ORDER, 0));
    plan.push_back(byte_row(8'd9, 1, 0, 3, 1, 0, 0, 1));
    plan.push_back(byte_row(8'd9, 1, 1, 3, 1, 0, 0, 0));
    plan.push_back(cfg_row(dsv_pkg::REG_ORDER, 1));
    plan.push_back(byte_row(8'd255, 1, 0, 0, 1, 0, 0, 1));
    plan.push_back(cfg_row(dsv_pkg::REG_ORDER, 11));
    plan.push_back(cfg_row(dsv_pkg::REG_PRIME, 0));
    plan.push_back(byte_row(8'd3, 1, 0, 1, 1, 0, 3, 1));
    plan.push_back(cfg_row(dsv_pkg::REG_PRIME, 1));
    plan.push_back(byte_row(8'd4, 1, 0, 2, 1, 0, 4, 1));
    plan.push_back(cfg_row(dsv_pkg::REG_PRIME, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(dsv_pkg::REG_ORDER, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(dsv_pkg::REG_GEN, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(dsv_pkg::REG_KEY, 32'hFFFF_FFFF));
    plan.push_back(byte_row(8'd255, 0, 0, 0));
    plan.push_back(byte_row(8'd255, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
    plan.push_back(cfg_row(dsv_pkg::REG_ORDER, 1000));
    plan.push_back(byte_row(8'd250, 0, 0, 0));
    plan.push_back(byte_row(8'd250, 0, 0, 0));
    plan.push_back(cfg_row(dsv_pkg::REG_ORDER, 13));
    plan.push_back(byte_row(8'd1, 1, 5, 7));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_byte(plan[i].mbyte, plan[i].last, plan[i].r, plan[i].s, has, vd);
        if (has && plan[i].fixed &&
            (vd.v !== plan[i].ev || vd.h !== plan[i].eh || vd.ok !== plan[i].evalid))
          report_mismatch("directed row", vd.v, plan[i].ev);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin pp = $urandom_range(3, 5000); qq = $urandom_range(2, 300); end
        1: begin pp = $urandom; qq = $urandom_range(2, 4000); end
        2: begin pp = 32'hFFFF_FFFF; qq = $urandom_range(2, 64); end
        3: begin pp = $urandom | 32'h8000_0000; qq = $urandom | 32'h8000_0000; end
        default: begin pp = 23; qq = 11; end
      endcase
      write_reg(dsv_pkg::REG_PRIME, MW'(pp));
      write_reg(dsv_pkg::REG_ORDER, MW'(qq));
      write_reg(dsv_pkg::REG_GEN, (ph == 7) ? 32'd0 : $urandom);
      write_reg(dsv_pkg::REG_KEY, (ph == 8) ? 32'hFFFF_FFFF : MW'($urandom % (pp + 1)));
      for (int k = 0; k < 200; k++) begin
        int n;
        n = ph * 200 + k;
        idle_pct = (n < 700) ? 30 : (n < 1400) ? 80 : 0;
        if (k % 50 > 40) idle_pct = 0;
        rr = ($urandom_range(1)) ? SIG_W'($urandom % qq) : $urandom;
        send_byte(BYTE_W'($urandom_range(255)), $urandom_range(5) == 0, rr,
                  ($urandom_range(7) == 0) ? 32'd0 : $urandom, has, vd);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[dsa_signature_verify_top] OK");
    end else begin
      $display("[dsa_signature_verify_top] ERROR");
    end
    $finish;
  end

endmodule
